// ----- hw/rtl/ecd_pkg.sv -----
package ecd_pkg;

	localparam logic [62:0] MAX_EPOCH = 63'd253402300799;

	localparam int          DAY_SH   = 41;
	localparam logic [9:0]  DAY_DIV  = 10'd675;
	localparam logic [31:0] DAY_MUL  = 32'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);

	localparam logic [21:0] EPOCH_DAYS = 22'd719468;
	localparam logic [17:0] ERA_DAYS   = 18'd146097;
	localparam logic [17:0] ERA_LAST   = 18'd146096;
	localparam int          ERA_SH     = 40;
	localparam logic [22:0] ERA_MUL    = 23'(((64'd1 << ERA_SH) + 64'd146096) / 64'd146097);

	localparam int          LEAP4_SH  = 29;
	localparam logic [18:0] LEAP4_MUL = 19'(((64'd1 << LEAP4_SH) + 64'd1459) / 64'd1460);
	localparam int          CENT_SH   = 34;
	localparam logic [18:0] CENT_MUL  = 19'(((64'd1 << CENT_SH) + 64'd36523) / 64'd36524);
	localparam int          YEAR_SH   = 27;
	localparam logic [18:0] YEAR_MUL  = 19'(((64'd1 << YEAR_SH) + 64'd364) / 64'd365);
	localparam int          Y100_SH   = 16;
	localparam logic [9:0]  Y100_MUL  = 10'(((64'd1 << Y100_SH) + 64'd99) / 64'd100);
	localparam int          MP_SH     = 19;
	localparam logic [11:0] MP_MUL    = 12'(((64'd1 << MP_SH) + 64'd152) / 64'd153);

	localparam int          HOUR_SH  = 21;
	localparam logic [13:0] HOUR_MUL = 14'(((64'd1 << HOUR_SH) + 64'd224) / 64'd225);
	localparam int          WD_SH    = 25;
	localparam logic [22:0] WD_MUL   = 23'(((64'd1 << WD_SH) + 64'd6) / 64'd7);
	localparam int          MIN_SH   = 14;
	localparam logic [10:0] MIN_MUL  = 11'(((64'd1 << MIN_SH) + 64'd14) / 64'd15);

	localparam logic [13:0] MIN_YEAR = 14'd1970;
	localparam logic [13:0] MAX_YEAR = 14'd9999;

	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
	} ecd_date_t;

	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} ecd_tod_t;

	typedef struct packed {
		logic        valid_res;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} ecd_res_t;

	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] off;
		case (mp)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

// ----- hw/rtl/ecd_split.sv -----
module ecd_split (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [63:0] epoch_seconds,
	output logic        vld_s3,
	output logic        ok_s3,
	output logic [21:0] days_s3,
	output logic [16:0] daily_s3
);

	logic        vld_s1, vld_s2;
	logic        ok_s1, ok_s2;
	logic [37:0] sec_s1;
	logic [21:0] days_s2;
	logic [30:0] x_s2;
	logic [6:0]  lo_s2;
	logic [62:0] prod_days;
	logic [30:0] rem_day;

	assign prod_days = 63'(sec_s1[37:7]) * 63'(ecd_pkg::DAY_MUL);
	assign rem_day   = x_s2 - 31'(days_s2) * 31'(ecd_pkg::DAY_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= ~epoch_seconds[63] && (epoch_seconds[62:0] <= ecd_pkg::MAX_EPOCH);
			sec_s1   <= epoch_seconds[37:0];
			ok_s2    <= ok_s1;
			days_s2  <= prod_days[ecd_pkg::DAY_SH +: 22];
			x_s2     <= sec_s1[37:7];
			lo_s2    <= sec_s1[6:0];
			ok_s3    <= ok_s2;
			days_s3  <= days_s2;
			daily_s3 <= {rem_day[9:0], lo_s2};
		end
	end

endmodule

// ----- hw/rtl/ecd_tod.sv -----
module ecd_tod (
	input  logic               clk,
	input  logic               en,
	input  logic [21:0]        days_s3,
	input  logic [16:0]        daily_s3,
	output ecd_pkg::ecd_tod_t  tod
);

	logic [21:0] dw_s4, dw_s5;
	logic [16:0] daily_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7;
	logic [19:0] q7_s5;
	logic [11:0] remh_s5, remh_s6;
	logic [2:0]  wd_s6, wd_s7;
	logic [5:0]  min_s6, min_s7;
	logic [5:0]  sec_s7;
	ecd_pkg::ecd_tod_t pad_s8, pad_s9, pad_s10, pad_s11, pad_s12;

	logic [26:0] prod_hour;
	logic [44:0] prod_wd;
	logic [20:0] prod_min;
	logic [16:0] remh_full;
	logic [21:0] wd_full;
	logic [11:0] sec_full;

	assign prod_hour = 27'(daily_s3[16:4]) * 27'(ecd_pkg::HOUR_MUL);
	assign prod_wd   = 45'(dw_s4) * 45'(ecd_pkg::WD_MUL);
	assign remh_full = daily_s4 - 17'(hour_s4) * 17'd3600;
	assign prod_min  = 21'(remh_s5[11:2]) * 21'(ecd_pkg::MIN_MUL);
	assign wd_full   = dw_s5 - 22'(q7_s5) * 22'd7;
	assign sec_full  = remh_s6 - 12'(min_s6) * 12'd60;

	always_ff @(posedge clk) begin
		if (en) begin
			dw_s4    <= days_s3 + 22'd4;
			daily_s4 <= daily_s3;
			hour_s4  <= prod_hour[ecd_pkg::HOUR_SH +: 5];
			dw_s5    <= dw_s4;
			q7_s5    <= prod_wd[ecd_pkg::WD_SH +: 20];
			remh_s5  <= remh_full[11:0];
			hour_s5  <= hour_s4;
			wd_s6    <= wd_full[2:0];
			min_s6   <= prod_min[ecd_pkg::MIN_SH +: 6];
			remh_s6  <= remh_s5;
			hour_s6  <= hour_s5;
			wd_s7    <= wd_s6;
			min_s7   <= min_s6;
			sec_s7   <= sec_full[5:0];
			hour_s7  <= hour_s6;
			pad_s8   <= '{weekday: wd_s7, hour: hour_s7, minute: min_s7, second: sec_s7};
			pad_s9   <= pad_s8;
			pad_s10  <= pad_s9;
			pad_s11  <= pad_s10;
			pad_s12  <= pad_s11;
		end
	end

	assign tod = pad_s12;

endmodule

// ----- hw/rtl/ecd_civil.sv -----
module ecd_civil (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_s3,
	input  logic                ok_s3,
	input  logic [21:0]         days_s3,
	output logic                vld_s12,
	output ecd_pkg::ecd_date_t  date
);

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10, ok_s11, ok_s12;

	logic [21:0] d_s4, d_s5;
	logic [4:0]  era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [17:0] doe_s6, doe_s7, doe_s8, doe_s9, doe_s10;
	logic [6:0]  a_s7;
	logic [2:0]  b_s7;
	logic        c_s7;
	logic [17:0] t_s8;
	logic [8:0]  yoe_s9;
	logic [17:0] yc_s10;
	logic [13:0] y0_s10, y0_s11, y0_s12;
	logic [8:0]  doy_s11, doy_s12;
	logic [10:0] n5_s11;
	logic [3:0]  mp_s12;

	logic [44:0] prod_era;
	logic [21:0] doe_full;
	logic [36:0] prod_a, prod_b, prod_yoe;
	logic [18:0] prod_y100;
	logic [17:0] doy_full;
	logic [22:0] prod_mp;
	logic [8:0]  day_full;
	logic [3:0]  month_c;
	logic [13:0] year_c;

	assign prod_era  = 45'(d_s4) * 45'(ecd_pkg::ERA_MUL);
	assign doe_full  = d_s5 - 22'(era_s5) * 22'(ecd_pkg::ERA_DAYS);
	assign prod_a    = 37'(doe_s6) * 37'(ecd_pkg::LEAP4_MUL);
	assign prod_b    = 37'(doe_s6) * 37'(ecd_pkg::CENT_MUL);
	assign prod_yoe  = 37'(t_s8) * 37'(ecd_pkg::YEAR_MUL);
	assign prod_y100 = 19'(yoe_s9) * 19'(ecd_pkg::Y100_MUL);
	assign doy_full  = doe_s10 - yc_s10;
	assign prod_mp   = 23'(n5_s11) * 23'(ecd_pkg::MP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4   <= ok_s3;
			d_s4    <= days_s3 + ecd_pkg::EPOCH_DAYS;

			ok_s5   <= ok_s4;
			d_s5    <= d_s4;
			era_s5  <= prod_era[ecd_pkg::ERA_SH +: 5];

			ok_s6   <= ok_s5;
			doe_s6  <= doe_full[17:0];
			era_s6  <= era_s5;

			ok_s7   <= ok_s6;
			a_s7    <= prod_a[ecd_pkg::LEAP4_SH +: 7];
			b_s7    <= prod_b[ecd_pkg::CENT_SH +: 3];
			c_s7    <= (doe_s6 == ecd_pkg::ERA_LAST);
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;

			ok_s8   <= ok_s7;
			t_s8    <= doe_s7 - 18'(a_s7) + 18'(b_s7) - 18'(c_s7);
			doe_s8  <= doe_s7;
			era_s8  <= era_s7;

			ok_s9   <= ok_s8;
			yoe_s9  <= prod_yoe[ecd_pkg::YEAR_SH +: 9];
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;

			ok_s10  <= ok_s9;
			yc_s10  <= 18'(yoe_s9) * 18'd365 + 18'(yoe_s9[8:2])
				- 18'(prod_y100[ecd_pkg::Y100_SH +: 3]);
			y0_s10  <= 14'(yoe_s9) + 14'(era_s9) * 14'd400;
			doe_s10 <= doe_s9;

			ok_s11  <= ok_s10;
			doy_s11 <= doy_full[8:0];
			n5_s11  <= 11'(doy_full[8:0]) * 11'd5 + 11'd2;
			y0_s11  <= y0_s10;

			ok_s12  <= ok_s11;
			mp_s12  <= prod_mp[ecd_pkg::MP_SH +: 4];
			doy_s12 <= doy_s11;
			y0_s12  <= y0_s11;
		end
	end

	always_comb begin
		day_full = doy_s12 - ecd_pkg::month_offset(mp_s12) + 9'd1;
		month_c  = (mp_s12 < 4'd10) ? mp_s12 + 4'd3 : mp_s12 - 4'd9;
		year_c   = y0_s12 + 14'(month_c <= 4'd2);
		date.ok           = ok_s12 && (year_c >= ecd_pkg::MIN_YEAR)
			&& (year_c <= ecd_pkg::MAX_YEAR);
		date.year         = year_c;
		date.month        = month_c;
		date.day_of_month = day_full[4:0];
	end

endmodule

// ----- hw/rtl/ecd_out.sv -----
module ecd_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  ecd_pkg::ecd_res_t  in_res,
	input  logic               out_stall,
	output logic               out_valid,
	output ecd_pkg::ecd_res_t  out_res,
	output logic               en
);

	logic              out_vld_q, skid_vld_q;
	ecd_pkg::ecd_res_t out_q, skid_q;
	logic              take;

	assign take      = out_vld_q && !out_stall;
	assign en        = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_vld) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (in_vld) begin
			if (out_vld_q && !take) begin
				skid_q <= in_res;
			end else begin
				out_q <= in_res;
			end
		end
	end

endmodule

// ----- hw/rtl/epoch_seconds_to_civil_datetime_unit.sv -----
// Channel  Handshake            Payload
// in       in_valid, in_stall   epoch_seconds
// out      out_valid, out_stall valid_res, year, month, day_of_month, weekday,
//                               hour, minute, second
//
// One word enters per cycle while in_stall is low.
// Twelve pipeline stages feed an output register; the stage count is set by the
// chain of constant divisions from seconds to year, each a multiply by a reciprocal.
// Reset clears only the valid bits and the output and skid flags.
// A stalled output word holds; one more word lands in the skid register, and
// in_stall stays high while that register is full, freezing every stage.
module epoch_seconds_to_civil_datetime_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [2:0]  weekday,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic               en;
	logic               vld_s3, ok_s3, vld_s12;
	logic [21:0]        days_s3;
	logic [16:0]        daily_s3;
	ecd_pkg::ecd_date_t date;
	ecd_pkg::ecd_tod_t  tod;
	ecd_pkg::ecd_res_t  res, out_res;

	assign in_stall = !en;

	ecd_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (in_valid),
		.epoch_seconds (epoch_seconds),
		.vld_s3        (vld_s3),
		.ok_s3         (ok_s3),
		.days_s3       (days_s3),
		.daily_s3      (daily_s3)
	);

	ecd_civil u_civil (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s3  (vld_s3),
		.ok_s3   (ok_s3),
		.days_s3 (days_s3),
		.vld_s12 (vld_s12),
		.date    (date)
	);

	ecd_tod u_tod (
		.clk      (clk),
		.en       (en),
		.days_s3  (days_s3),
		.daily_s3 (daily_s3),
		.tod      (tod)
	);

	// zero every field of a rejected count
	always_comb begin
		res.valid_res    = date.ok;
		res.year         = date.ok ? date.year : '0;
		res.month        = date.ok ? date.month : '0;
		res.day_of_month = date.ok ? date.day_of_month : '0;
		res.weekday      = date.ok ? tod.weekday : '0;
		res.hour         = date.ok ? tod.hour : '0;
		res.minute       = date.ok ? tod.minute : '0;
		res.second       = date.ok ? tod.second : '0;
	end

	ecd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s12),
		.in_res    (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.en        (en)
	);

	assign valid_res    = out_res.valid_res;
	assign year         = out_res.year;
	assign month        = out_res.month;
	assign day_of_month = out_res.day_of_month;
	assign weekday      = out_res.weekday;
	assign hour         = out_res.hour;
	assign minute       = out_res.minute;
	assign second       = out_res.second;

endmodule
